### sv/nodal_verlet_element_average_unit_assert.svh
// Assertion macros for the nodal Verlet element average unit.
// Included by the top level only.
`ifndef NODAL_VERLET_ELEMENT_AVERAGE_UNIT_ASSERT_SVH
`define NODAL_VERLET_ELEMENT_AVERAGE_UNIT_ASSERT_SVH
`define NVEA_ASSERT_IMPL(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
`define NVEA_ASSERT_NEXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`endif

### sv/nvea_pkg.sv
// Package of the nodal Verlet element average unit: word types and constants.
// No dependencies.
package nvea_pkg;
  localparam int unsigned MaxNodesDefault = 64;
  localparam int unsigned FracBitsDefault = 16;
  localparam int unsigned SumW = 38;

  localparam logic [1:0] RecNode = 2'd0;
  localparam logic [1:0] RecAvgPv = 2'd1;
  localparam logic [1:0] RecAvgF = 2'd2;

  localparam logic PAddrPosStep = 1'b0;
  localparam logic PAddrVelStep = 1'b1;

  typedef struct packed {
    logic        kind;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
    logic signed [31:0] force_x;
    logic signed [31:0] force_y;
    logic signed [31:0] force_z;
    logic [31:0] node_mass;
    logic        last_node;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  record;
    logic signed [31:0] vec_a_x;
    logic signed [31:0] vec_a_y;
    logic signed [31:0] vec_a_z;
    logic signed [31:0] vec_b_x;
    logic signed [31:0] vec_b_y;
    logic signed [31:0] vec_b_z;
    logic        last_result;
  } out_word_t;

  typedef struct packed {
    logic start;
    logic is_signed;
  } div_ctl_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic signed [SumW-1:0] sat38(input logic signed [SumW:0] v);
    if (v[SumW] != v[SumW-1]) return {v[SumW], {(SumW-1){~v[SumW]}}};
    return v[SumW-1:0];
  endfunction
endpackage

### sv/nvea_div.sv
// Radix-2 restoring divider, one quotient bit per cycle, 48-bit dividend.
// Depends on nvea_pkg for the control struct.
module nvea_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  nvea_pkg::div_ctl_t ctl_i,
  input  logic [47:0]       num_i,
  input  logic [31:0]       den_i,
  output logic              busy_o,
  output logic [47:0]       quo_o
);
  logic [47:0] q_q, q_d;
  logic [32:0] r_q, r_d;
  logic [31:0] d_q;
  logic [5:0]  cnt_q, cnt_d;
  logic        neg_q;
  logic [32:0] trial;
  logic [47:0] mag;

  assign mag = (ctl_i.is_signed && num_i[47]) ? (48'd0 - num_i) : num_i;
  assign trial = {r_q[31:0], q_q[47]} - {1'b0, d_q};

  always_comb begin
    q_d = q_q;
    r_d = r_q;
    cnt_d = cnt_q;
    if (cnt_q != 6'd0) begin
      if (!trial[32]) begin
        r_d = trial;
        q_d = {q_q[46:0], 1'b1};
      end else begin
        r_d = {r_q[31:0], q_q[47]};
        q_d = {q_q[46:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 6'd0;
    end else if (ctl_i.start) begin
      cnt_q <= 6'd48;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.start) begin
      q_q <= mag;
      r_q <= 33'd0;
      d_q <= den_i;
      neg_q <= ctl_i.is_signed && num_i[47];
    end else begin
      q_q <= q_d;
      r_q <= r_d;
    end
  end

  assign busy_o = (cnt_q != 6'd0);
  assign quo_o = neg_q ? (48'd0 - q_q) : q_q;
endmodule

### sv/nvea_mul.sv
// Serial shift-add multiplier, 2 multiplier bits per cycle, signed 32 x unsigned 32.
// Depends on nothing.
module nvea_mul (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [31:0]        a_i,
  input  logic signed [31:0] b_i,
  output logic               busy_o,
  output logic signed [63:0] p_o
);
  logic signed [63:0] acc_q, bs_q;
  logic [31:0] a_q;
  logic [4:0]  cnt_q;
  logic signed [63:0] add1, add2;

  assign add1 = a_q[0] ? bs_q : 64'sd0;
  assign add2 = a_q[1] ? (bs_q <<< 1) : 64'sd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 5'd0;
    end else if (start_i) begin
      cnt_q <= 5'd16;
    end else if (cnt_q != 5'd0) begin
      cnt_q <= cnt_q - 5'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q <= 64'sd0;
      bs_q <= 64'(b_i);
      a_q <= a_i;
    end else if (cnt_q != 5'd0) begin
      acc_q <= acc_q + add1 + add2;
      bs_q <= bs_q <<< 2;
      a_q <= {2'b00, a_q[31:2]};
    end
  end

  assign busy_o = (cnt_q != 5'd0);
  assign p_o = acc_q;
endmodule

### sv/nodal_verlet_element_average_unit.sv
// Nodal Verlet element average unit: one node word in, one or three words out.
// Each node word runs a serial divide for the velocity scale, then six serial multiplies
// (three when kind is set, velocity only) before its word is emitted.
// A new node is taken only once the unit is back in idle; a last node adds nine serial
// average divides and then emits both average words. Output stalls add delay.
// Reset clears the state, step registers, sums and node count; depends on nvea_pkg.
module nodal_verlet_element_average_unit #(
  parameter int unsigned MaxNodes = nvea_pkg::MaxNodesDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  nvea_pkg::in_word_t  in_word_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output nvea_pkg::out_word_t out_word_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  localparam int unsigned CntW = $clog2(MaxNodes + 1);
  localparam int unsigned SW = nvea_pkg::SumW;
  localparam int unsigned FracBits = nvea_pkg::FracBitsDefault;

  typedef enum logic [6:0] {
    StIdle = 7'b0000001, StDiv = 7'b0000010, StMulV = 7'b0000100,
    StMulP = 7'b0001000, StOut = 7'b0010000, StAvg = 7'b0100000,
    StAvgOut = 7'b1000000
  } st_e;

  st_e st_q;
  logic [31:0] pstep_q, vstep_q, scale_q;
  nvea_pkg::in_word_t in_q;
  logic signed [31:0] vel_q [3];
  logic signed [31:0] pos_q [3];
  logic signed [SW-1:0] psum_q [3], vsum_q [3], fsum_q [3];
  logic signed [31:0] avg_q [9];
  logic [CntW-1:0] cnt_q;
  logic [1:0] ax_q;
  logic [3:0] ai_q;
  logic go_q;
  logic [1:0] rec_q;
  nvea_pkg::out_word_t out_q;
  logic out_v_q;

  nvea_pkg::div_ctl_t dctl;
  logic [47:0] dnum, dquo;
  logic [31:0] dden;
  logic dbusy, mbusy;
  logic [31:0] ma;
  logic signed [31:0] mb;
  logic signed [63:0] mp, msh;
  logic signed [SW-1:0] asrc;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == nvea_pkg::PAddrVelStep) ? vstep_q : pstep_q;
  assign in_stall_o = (st_q != StIdle);
  assign out_valid_o = out_v_q;
  assign out_word_o = out_q;

  always_comb begin
    unique case (ai_q)
      4'd0, 4'd1, 4'd2: asrc = psum_q[ai_q[1:0]];
      4'd3, 4'd4, 4'd5: asrc = vsum_q[2'(ai_q - 4'd3)];
      4'd6, 4'd7, 4'd8: asrc = fsum_q[2'(ai_q - 4'd6)];
      default: asrc = '0;
    endcase
  end

  assign dctl.start = go_q && (st_q == StDiv || st_q == StAvg);
  assign dctl.is_signed = (st_q == StAvg);
  assign dnum = (st_q == StAvg) ? 48'(asrc) : (48'(vstep_q) << FracBits);
  assign dden = (st_q == StAvg) ? 32'(cnt_q) : in_q.node_mass;
  assign ma = (st_q == StMulP) ? pstep_q : scale_q;
  always_comb begin
    unique case (ax_q)
      2'd0: mb = (st_q == StMulP) ? vel_q[0] : in_q.force_x;
      2'd1: mb = (st_q == StMulP) ? vel_q[1] : in_q.force_y;
      default: mb = (st_q == StMulP) ? vel_q[2] : in_q.force_z;
    endcase
  end
  assign msh = mp >>> FracBits;

  nvea_div u_div (.clk_i, .rst_ni, .ctl_i(dctl), .num_i(dnum), .den_i(dden),
    .busy_o(dbusy), .quo_o(dquo));
  nvea_mul u_mul (.clk_i, .rst_ni, .start_i(go_q && (st_q == StMulV || st_q == StMulP)),
    .a_i(ma), .b_i(mb), .busy_o(mbusy), .p_o(mp));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle;
      pstep_q <= '0;
      vstep_q <= '0;
      cnt_q <= '0;
      out_v_q <= 1'b0;
      go_q <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        psum_q[i] <= '0; vsum_q[i] <= '0; fsum_q[i] <= '0;
      end
    end else begin
      if (psel && penable && pwrite) begin
        if (paddr[2] == nvea_pkg::PAddrPosStep) pstep_q <= pwdata;
        else vstep_q <= pwdata;
      end
      if (out_v_q && !out_stall_i) out_v_q <= 1'b0;
      go_q <= 1'b0;
      unique case (st_q)
        StIdle: if (in_valid_i) begin
          in_q <= in_word_i;
          pos_q[0] <= in_word_i.pos_x;
          pos_q[1] <= in_word_i.pos_y;
          pos_q[2] <= in_word_i.pos_z;
          vel_q[0] <= in_word_i.vel_x;
          vel_q[1] <= in_word_i.vel_y;
          vel_q[2] <= in_word_i.vel_z;
          go_q <= 1'b1;
          st_q <= StDiv;
        end
        StDiv: if (!go_q && !dbusy) begin
          if (in_q.node_mass == 32'd0 || dquo[47:32] != 16'd0) scale_q <= '1;
          else scale_q <= dquo[31:0];
          ax_q <= 2'd0;
          go_q <= 1'b1;
          st_q <= StMulV;
        end
        StMulV: if (!go_q && !mbusy) begin
          vel_q[ax_q] <= nvea_pkg::sat32(64'(vel_q[ax_q]) + msh);
          go_q <= 1'b1;
          if (ax_q == 2'd2) begin
            ax_q <= 2'd0;
            if (in_q.kind) begin
              go_q <= 1'b0;
              st_q <= StOut;
            end else st_q <= StMulP;
          end else ax_q <= ax_q + 2'd1;
        end
        StMulP: if (!go_q && !mbusy) begin
          pos_q[ax_q] <= nvea_pkg::sat32(64'(pos_q[ax_q]) + msh);
          if (ax_q == 2'd2) st_q <= StOut;
          else begin
            ax_q <= ax_q + 2'd1;
            go_q <= 1'b1;
          end
        end
        StOut: if (!out_v_q) begin
          out_q <= '{record: nvea_pkg::RecNode, vec_a_x: pos_q[0], vec_a_y: pos_q[1],
            vec_a_z: pos_q[2], vec_b_x: vel_q[0], vec_b_y: vel_q[1], vec_b_z: vel_q[2],
            last_result: !in_q.last_node};
          out_v_q <= 1'b1;
          if (cnt_q < CntW'(MaxNodes)) begin
            for (int i = 0; i < 3; i++) begin
              if (!in_q.kind)
                psum_q[i] <= nvea_pkg::sat38((SW+1)'(psum_q[i]) + (SW+1)'(pos_q[i]));
              vsum_q[i] <= nvea_pkg::sat38((SW+1)'(vsum_q[i]) + (SW+1)'(vel_q[i]));
            end
            fsum_q[0] <= nvea_pkg::sat38((SW+1)'(fsum_q[0]) + (SW+1)'(in_q.force_x));
            fsum_q[1] <= nvea_pkg::sat38((SW+1)'(fsum_q[1]) + (SW+1)'(in_q.force_y));
            fsum_q[2] <= nvea_pkg::sat38((SW+1)'(fsum_q[2]) + (SW+1)'(in_q.force_z));
            cnt_q <= cnt_q + CntW'(1);
          end
          if (in_q.last_node) begin
            ai_q <= 4'd0;
            go_q <= 1'b1;
            st_q <= StAvg;
          end else st_q <= StIdle;
        end
        StAvg: if (!go_q && !dbusy) begin
          avg_q[ai_q] <= (in_q.kind && ai_q < 4'd3) ? 32'sd0 :
            nvea_pkg::sat32(64'(signed'(dquo)));
          if (ai_q == 4'd8) begin
            rec_q <= nvea_pkg::RecAvgPv;
            st_q <= StAvgOut;
          end else begin
            ai_q <= ai_q + 4'd1;
            go_q <= 1'b1;
          end
        end
        StAvgOut: if (!out_v_q) begin
          out_v_q <= 1'b1;
          if (rec_q == nvea_pkg::RecAvgPv) begin
            out_q <= '{record: nvea_pkg::RecAvgPv, vec_a_x: avg_q[0], vec_a_y: avg_q[1],
              vec_a_z: avg_q[2], vec_b_x: avg_q[3], vec_b_y: avg_q[4], vec_b_z: avg_q[5],
              last_result: 1'b0};
            rec_q <= nvea_pkg::RecAvgF;
          end else begin
            out_q <= '{record: nvea_pkg::RecAvgF, vec_a_x: avg_q[6], vec_a_y: avg_q[7],
              vec_a_z: avg_q[8], vec_b_x: 32'sd0, vec_b_y: 32'sd0, vec_b_z: 32'sd0,
              last_result: 1'b1};
            for (int i = 0; i < 3; i++) begin
              psum_q[i] <= '0; vsum_q[i] <= '0; fsum_q[i] <= '0;
            end
            cnt_q <= '0;
            st_q <= StIdle;
          end
        end
        default: st_q <= StIdle;
      endcase
    end
  end

`include "nodal_verlet_element_average_unit_assert.svh"
  `NVEA_ASSERT_IMPL(a_cnt_max, clk_i, rst_ni, 1'b1, cnt_q <= CntW'(MaxNodes))
  `NVEA_ASSERT_IMPL(a_avg_nonzero, clk_i, rst_ni, st_q == StAvg, cnt_q != '0)
  `NVEA_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_v_q && out_stall_i, out_v_q && $stable(out_q))
endmodule

### test/tb.sv
// Testbench for nodal_verlet_element_average_unit: drives node words, predicts the
// updated nodes and element averages, and compares every output word field by field.
// Depends on nvea_pkg and the unit's RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] AddrPosStep = 3'd0;
  localparam logic [2:0] AddrVelStep = 3'd4;
  localparam int MaxNodes = 64;
  localparam int DrainCycles = 700;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  nvea_pkg::in_word_t in_word_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  nvea_pkg::out_word_t out_word_o;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  nodal_verlet_element_average_unit dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_word_i,
    .out_valid_o, .out_stall_i, .out_word_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  nvea_pkg::in_word_t pending_nodes[$];
  nvea_pkg::out_word_t expected_words[$];
  logic [31:0] pos_step_q = '0;
  logic [31:0] vel_step_q = '0;
  longint pos_sum[3], vel_sum[3], frc_sum[3];
  int node_cnt = 0;
  int errors = 0;
  int send_gap = 0;
  int recv_stall = 0;
  bit send_burst = 0;
  bit recv_burst = 0;

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  function automatic longint clamp(longint v, longint hi);
    if (v > hi) return hi;
    if (v < -hi - 1) return -hi - 1;
    return v;
  endfunction

  task automatic report(string field, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h expected %h at %0t", field, got, want, $realtime);
    errors++;
  endtask

  task automatic predict_node(nvea_pkg::in_word_t w);
    logic [63:0] scale;
    longint p[3], v[3], f[3];
    nvea_pkg::out_word_t o;
    p = '{w.pos_x, w.pos_y, w.pos_z};
    v = '{w.vel_x, w.vel_y, w.vel_z};
    f = '{w.force_x, w.force_y, w.force_z};
    if (w.node_mass == 0) scale = 64'hFFFFFFFF;
    else begin
      scale = ({32'b0, vel_step_q} << 16) / {32'b0, w.node_mass};
      if (scale > 64'hFFFFFFFF) scale = 64'hFFFFFFFF;
    end
    for (int i = 0; i < 3; i++) begin
      v[i] = clamp(v[i] + ((longint'(scale) * f[i]) >>> 16), 64'sd2147483647);
      if (!w.kind)
        p[i] = clamp(p[i] + ((longint'({32'b0, pos_step_q}) * v[i]) >>> 16), 64'sd2147483647);
    end
    if (node_cnt < MaxNodes) begin
      for (int i = 0; i < 3; i++) begin
        if (!w.kind) pos_sum[i] = clamp(pos_sum[i] + p[i], (64'sd1 <<< 37) - 1);
        vel_sum[i] = clamp(vel_sum[i] + v[i], (64'sd1 <<< 37) - 1);
        frc_sum[i] = clamp(frc_sum[i] + f[i], (64'sd1 <<< 37) - 1);
      end
      node_cnt++;
    end
    o.record = nvea_pkg::RecNode;
    o.vec_a_x = p[0][31:0]; o.vec_a_y = p[1][31:0]; o.vec_a_z = p[2][31:0];
    o.vec_b_x = v[0][31:0]; o.vec_b_y = v[1][31:0]; o.vec_b_z = v[2][31:0];
    o.last_result = !w.last_node;
    expected_words.push_back(o);
    if (w.last_node) begin
      for (int i = 0; i < 3; i++) begin
        p[i] = w.kind ? 0 : clamp(pos_sum[i] / node_cnt, 64'sd2147483647);
        v[i] = clamp(vel_sum[i] / node_cnt, 64'sd2147483647);
        f[i] = clamp(frc_sum[i] / node_cnt, 64'sd2147483647);
      end
      o.record = nvea_pkg::RecAvgPv;
      o.vec_a_x = p[0][31:0]; o.vec_a_y = p[1][31:0]; o.vec_a_z = p[2][31:0];
      o.vec_b_x = v[0][31:0]; o.vec_b_y = v[1][31:0]; o.vec_b_z = v[2][31:0];
      o.last_result = 1'b0;
      expected_words.push_back(o);
      o.record = nvea_pkg::RecAvgF;
      o.vec_a_x = f[0][31:0]; o.vec_a_y = f[1][31:0]; o.vec_a_z = f[2][31:0];
      o.vec_b_x = '0; o.vec_b_y = '0; o.vec_b_z = '0;
      o.last_result = 1'b1;
      expected_words.push_back(o);
      pos_sum = '{0, 0, 0}; vel_sum = '{0, 0, 0}; frc_sum = '{0, 0, 0};
      node_cnt = 0;
    end
  endtask

  // Sender: hold the word while stalled, then wait a drawn gap before the next.
  always @(posedge clk_i) begin
    logic busy;
    busy = in_valid_i;
    if (in_valid_i && !in_stall_o) begin
      predict_node(in_word_i);
      busy = 1'b0;
    end
    if (!busy) begin
      if (send_gap > 0) send_gap--;
      else if (pending_nodes.size() > 0) begin
        in_word_i <= pending_nodes.pop_front();
        busy = 1'b1;
        if ($urandom_range(0, 15) == 0) send_burst = ~send_burst;
        send_gap = send_burst ? 0 : $urandom_range(0, 11);
      end
    end
    in_valid_i <= busy;
  end

  // Receiver: check each accepted word, then draw the next stall.
  always @(posedge clk_i) begin
    nvea_pkg::out_word_t want;
    if (out_valid_o && !out_stall_i) begin
      if (expected_words.size() == 0) report("unexpected word", '0, '0);
      else begin
        want = expected_words.pop_front();
        if (out_word_o.record !== want.record) report("record", out_word_o.record, want.record);
        if (out_word_o.vec_a_x !== want.vec_a_x) report("vec_a_x", out_word_o.vec_a_x, want.vec_a_x);
        if (out_word_o.vec_a_y !== want.vec_a_y) report("vec_a_y", out_word_o.vec_a_y, want.vec_a_y);
        if (out_word_o.vec_a_z !== want.vec_a_z) report("vec_a_z", out_word_o.vec_a_z, want.vec_a_z);
        if (out_word_o.vec_b_x !== want.vec_b_x) report("vec_b_x", out_word_o.vec_b_x, want.vec_b_x);
        if (out_word_o.vec_b_y !== want.vec_b_y) report("vec_b_y", out_word_o.vec_b_y, want.vec_b_y);
        if (out_word_o.vec_b_z !== want.vec_b_z) report("vec_b_z", out_word_o.vec_b_z, want.vec_b_z);
        if (out_word_o.last_result !== want.last_result)
          report("last_result", out_word_o.last_result, want.last_result);
      end
      if ($urandom_range(0, 15) == 0) recv_burst = ~recv_burst;
      recv_stall = recv_burst ? 0 : $urandom_range(0, 11);
    end else if (recv_stall > 0) recv_stall--;
    out_stall_i <= (recv_stall != 0);
  end

  task automatic write_reg(logic [2:0] addr, logic [31:0] data);
    @(posedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0; paddr <= addr; pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (addr == AddrPosStep) pos_step_q = data;
    else vel_step_q = data;
  endtask

  task automatic set_steps(logic [31:0] pos_step, logic [31:0] vel_step);
    write_reg(AddrPosStep, pos_step);
    write_reg(AddrVelStep, vel_step);
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
      default: return $urandom_range(0, 1 << 22) - (1 << 21);
    endcase
  endfunction

  function automatic logic [31:0] pick_mass();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return $urandom;
      default: return $urandom_range(1 << 12, 1 << 20);
    endcase
  endfunction

  function automatic nvea_pkg::in_word_t make_node(logic kind, logic last);
    nvea_pkg::in_word_t w;
    w.kind = kind;
    w.pos_x = pick_value(); w.pos_y = pick_value(); w.pos_z = pick_value();
    w.vel_x = pick_value(); w.vel_y = pick_value(); w.vel_z = pick_value();
    w.force_x = pick_value(); w.force_y = pick_value(); w.force_z = pick_value();
    w.node_mass = pick_mass();
    w.last_node = last;
    return w;
  endfunction

  task automatic queue_element(int len, int kind_mode);
    logic kind;
    for (int n = 0; n < len; n++) begin
      kind = (kind_mode == 2) ? $urandom_range(0, 1) : kind_mode[0];
      pending_nodes.push_back(make_node(kind, n == len - 1));
    end
  endtask

  task automatic drain();
    while (pending_nodes.size() > 0 || in_valid_i || expected_words.size() > 0)
      @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic queue_random(int items);
    int len;
    while (items > 0) begin
      len = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(2, 6);
      queue_element(len, $urandom_range(0, 3) == 3 ? 2 : $urandom_range(0, 1));
      items -= len;
    end
  endtask

  initial begin
    nvea_pkg::in_word_t w;
    pos_sum = '{0, 0, 0}; vel_sum = '{0, 0, 0}; frc_sum = '{0, 0, 0};
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    set_steps(32'h0001_0000, 32'h0000_8000);
    w = '0;
    w.node_mass = 32'h0001_0000;
    w.pos_x = 32'h7FFFFFFF; w.vel_x = 32'h7FFFFFFF; w.force_x = 32'h7FFFFFFF;
    w.pos_y = 32'h80000000; w.vel_y = 32'h80000000; w.force_y = 32'h80000000;
    w.last_node = 1'b1;
    pending_nodes.push_back(w);
    w.kind = 1'b1;
    pending_nodes.push_back(w);
    w.node_mass = '0; w.kind = 1'b0; w.last_node = 1'b0;
    pending_nodes.push_back(w);
    w.node_mass = 32'h1; w.last_node = 1'b1;
    pending_nodes.push_back(w);
    w.node_mass = 32'hFFFFFFFF; w.kind = 1'b1;
    pending_nodes.push_back(w);
    queue_element(4, 2);
    queue_element(3, 1);
    queue_element(1, 0);
    drain();

    set_steps(32'h0, 32'h0);
    queue_random(40);
    drain();
    set_steps(32'hFFFFFFFF, 32'hFFFFFFFF);
    queue_random(40);
    drain();
    set_steps($urandom_range(0, 1 << 17), $urandom_range(0, 1 << 17));
    queue_element(MaxNodes + 6, 2);
    queue_random(60);
    drain();
    set_steps($urandom, $urandom);
    queue_random(55);
    drain();

    if (errors == 0) $display("tb: clean");
    else $display("tb: errors");
    $finish;
  end

  initial begin
    #40ms;
    $display("tb: errors");
    $finish;
  end
endmodule

### files.f
+incdir+sv
sv/nvea_pkg.sv
sv/nvea_div.sv
sv/nvea_mul.sv
sv/nodal_verlet_element_average_unit.sv
test/tb.sv
